// ===== src/lru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// shared widths and types for the lru page replacement block
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int FRAMES  = 8;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int PAGE_W  = 16;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 4;
  localparam int FIDX_W  = 3;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;

  // register index of frames_in_use
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // search results rippling along the row of frame cells
  typedef struct packed {
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic              old_found;
    logic [IDX_W-1:0]  old_idx;
    logic [RANK_W-1:0] old_rank;
    logic [PAGE_W-1:0] old_page;
  } chain_t;

  // update broadcast to every cell
  typedef struct packed {
    logic              clear;
    logic              write;
    logic [IDX_W-1:0]  tgt;
    logic              age_all;
    logic [RANK_W-1:0] limit;
    logic              load;
    logic              fill;
  } cmd_t;

endpackage

// ===== src/lru_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cell
// one frame: page, valid mark and recency rank, plus its link of the search chain
// ----------------------------------------------------------------------------
module lru_cell import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  idx,
  input  logic              active,
  input  logic [PAGE_W-1:0] ref_page,
  input  cmd_t              cmd,
  input  chain_t            chain_in,
  output chain_t            chain_out
);

  logic [PAGE_W-1:0] page;
  logic              valid;
  logic [RANK_W-1:0] rank;
  logic              match;

  assign match = active && valid && (page == ref_page);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit_found && match) begin
      chain_out.hit_found = 1'b1;
      chain_out.hit_idx   = idx;
      chain_out.hit_rank  = rank;
    end
    if (!chain_in.empty_found && active && !valid) begin
      chain_out.empty_found = 1'b1;
      chain_out.empty_idx   = idx;
    end
    // strictly older wins, so the lowest index keeps a tie
    if (active && (!chain_in.old_found || rank > chain_in.old_rank)) begin
      chain_out.old_found = 1'b1;
      chain_out.old_idx   = idx;
      chain_out.old_rank  = rank;
      chain_out.old_page  = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.write) begin
      if (cmd.tgt == idx) begin
        rank <= '0;
        if (cmd.fill) begin
          valid <= 1'b1;
        end
      end else if (valid && (cmd.age_all || rank < cmd.limit)) begin
        rank <= RANK_W'(rank + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd.load && cmd.tgt == idx) begin
      page <= ref_page;
    end
  end

endmodule

// ===== src/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// least recently used page replacement over a row of frame cells
// ----------------------------------------------------------------------------
// Each item carries one page reference and gives one result. The accept
// cycle latches the reference (and clears frames and counters when
// first_of_run is set); in the look state the search then runs in a single
// ripple along the row of frame cells and the update and the result register
// are written. A new item is taken only once the last one has been written,
// so items never overlap. A result waiting in the output register holds back
// the update of the next item only, not its acceptance. frames_in_use lives
// at byte address 0 of the APB port; 0 acts as one frame, anything above the
// row length as the full row. There is no clearing pass after reset: the
// valid marks clear at once.
// ----------------------------------------------------------------------------
module lru_page_replacement import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // reference items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       page_number,
  input  logic              first_of_run,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [2:0]        frame_index,
  output logic              evicted_valid,
  output logic [15:0]       evicted_page,
  output logic [15:0]       fault_total,
  output logic [15:0]       hit_total,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t            state;
  logic [CFG_W-1:0]  frames_in_use;
  logic [PAGE_W-1:0] ref_page;
  logic [CNT_W-1:0]  fault_counter;
  logic [CNT_W-1:0]  hit_counter;
  logic [CNT_W-1:0]  fault_counter_next;
  logic [CNT_W-1:0]  hit_counter_next;

  logic              accept;
  logic              commit;
  logic [FRAMES-1:0] active;
  chain_t            chain [FRAMES+1];
  chain_t            found;
  cmd_t              cmd;

  // configuration port, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? APB_DW'(frames_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // active set: frame 0 always takes part, the rest while below frames_in_use
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (int'(frames_in_use) > i);
    end
  end

  // row of frame cells, search results handed from cell to cell
  assign chain[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(g)),
      .active    (active[g]),
      .ref_page  (ref_page),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  assign found = chain[FRAMES];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // update only when the result register is free or being drained
  assign commit   = (state == S_LOOK) && (!out_valid || out_ready);

  // pick the frame: hit, else lowest empty frame, else the oldest one
  always_comb begin
    cmd       = '0;
    cmd.clear = accept && first_of_run;
    cmd.write = commit;
    if (found.hit_found) begin
      cmd.tgt   = found.hit_idx;
      cmd.limit = found.hit_rank;
    end else if (found.empty_found) begin
      cmd.tgt     = found.empty_idx;
      cmd.age_all = 1'b1;
      cmd.load    = 1'b1;
      cmd.fill    = 1'b1;
    end else begin
      cmd.tgt   = found.old_idx;
      cmd.limit = found.old_rank;
      cmd.load  = 1'b1;
    end
  end

  // saturating run counters
  assign fault_counter_next = (!found.hit_found && fault_counter != CNT_MAX) ?
                              CNT_W'(fault_counter + 1'b1) : fault_counter;
  assign hit_counter_next   = (found.hit_found && hit_counter != CNT_MAX) ?
                              CNT_W'(hit_counter + 1'b1) : hit_counter;

  // state, counters, item payload and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      fault_counter <= '0;
      hit_counter   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_LOOK;
            ref_page <= page_number;
            if (first_of_run) begin
              fault_counter <= '0;
              hit_counter   <= '0;
            end
          end
        end
        S_LOOK: begin
          if (commit) begin
            state         <= S_IDLE;
            fault_counter <= fault_counter_next;
            hit_counter   <= hit_counter_next;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (commit) begin
        out_valid     <= 1'b1;
        hit           <= found.hit_found;
        frame_index   <= FIDX_W'(cmd.tgt);
        evicted_valid <= !found.hit_found && !found.empty_found;
        evicted_page  <= (!found.hit_found && !found.empty_found) ? found.old_page : '0;
        fault_total   <= fault_counter_next;
        hit_total     <= hit_counter_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/lru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_checker
// port level checks on the lru page replacement block
// ----------------------------------------------------------------------------
module lru_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic        evicted_valid,
  input logic [15:0] evicted_page,
  input logic [15:0] hit_total
);

  // a held result stays valid and keeps its evicted page
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(evicted_page))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // an eviction only happens on a fault, and a result without an eviction shows page zero
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> !hit)
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == 16'd0)
    else $error("evicted page not zero without eviction");

  // a hit is always counted
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_total != 16'd0)
    else $error("hit with zero hit count");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .hit_total     (hit_total)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru page replacement block
// ----------------------------------------------------------------------------
// A queue of page references, filled phase by phase from the initial block,
// feeds a clocked driver. A clocked monitor predicts the outcome of every
// accepted reference from its own copy of the frame table and compares each
// result field by field. frames_in_use is rewritten over the apb port
// between phases, only once the block has drained. Random traffic works over
// small sets of pages so that hits, fills and evictions all occur.
// ----------------------------------------------------------------------------
module testbench;
  import lru_pkg::*;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 50;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_REFS   = 217;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              first;
  } page_ref_t;

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [CNT_W-1:0]  faults;
    logic [CNT_W-1:0]  hits;
  } ref_outcome_t;

  // block ports, every input known from time zero
  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [15:0]       page_number   = '0;
  logic              first_of_run  = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic              hit;
  logic [2:0]        frame_index;
  logic              evicted_valid;
  logic [15:0]       evicted_page;
  logic [15:0]       fault_total;
  logic [15:0]       hit_total;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [APB_DW-1:0] pwdata        = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lru_page_replacement DUT (.*);

  always #2 clk = ~clk;

  // shadow frame table
  logic [PAGE_W-1:0] shadow_page  [FRAMES];
  logic              shadow_valid [FRAMES];
  int                shadow_age   [FRAMES];
  logic [CNT_W-1:0]  shadow_faults;
  logic [CNT_W-1:0]  shadow_hits;
  logic [CFG_W-1:0]  shadow_frames_cfg = FRAMES_RESET;

  // references waiting to be offered, outcomes waiting for their result item
  page_ref_t    ref_queue [$];
  ref_outcome_t awaiting_results [$];

  int  refs_queued    = 0;
  int  refs_accepted  = 0;
  int  results_seen   = 0;
  int  hits_seen      = 0;
  int  evictions_seen = 0;
  int  mismatches     = 0;
  int  settings_used  = 0;
  int  cycle_count    = 0;
  bit  in_taken       = 1'b0;

  // idling percentages and the receiver hold-off request
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  int  hold_asks      = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;

  function automatic void clear_frames();
    for (int i = 0; i < FRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i]   = 0;
    end
    shadow_faults = '0;
    shadow_hits   = '0;
  endfunction

  // frame k becomes most recent; valid frames younger than limit grow older
  function automatic void make_recent(int k, int limit);
    for (int i = 0; i < FRAMES; i++)
      if (shadow_valid[i] && i != k && shadow_age[i] < limit)
        shadow_age[i]++;
    shadow_age[k] = 0;
  endfunction

  function automatic ref_outcome_t predict_lookup(page_ref_t r);
    ref_outcome_t o;
    int           active;
    int           k;
    bit           found;
    o = '0;
    if (shadow_frames_cfg == 0)
      active = 1;
    else if (shadow_frames_cfg > FRAMES)
      active = FRAMES;
    else
      active = shadow_frames_cfg;
    if (r.first)
      clear_frames();
    k = 0;
    found = 1'b0;
    // lowest-index match wins when a page sits in two frames
    for (int i = 0; i < active && !found; i++)
      if (shadow_valid[i] && shadow_page[i] == r.page) begin
        found = 1'b1;
        k = i;
      end
    if (found) begin
      o.hit = 1'b1;
      make_recent(k, shadow_age[k]);
      if (shadow_hits != CNT_MAX)
        shadow_hits++;
    end else begin
      for (int i = 0; i < active && !found; i++)
        if (!shadow_valid[i]) begin
          found = 1'b1;
          k = i;
        end
      if (found) begin
        shadow_valid[k] = 1'b1;
        make_recent(k, 255);
      end else begin
        k = 0;
        for (int i = 1; i < active; i++)
          if (shadow_age[i] > shadow_age[k])
            k = i;
        o.ev_valid = 1'b1;
        o.ev_page  = shadow_page[k];
        make_recent(k, shadow_age[k]);
      end
      shadow_page[k] = r.page;
      if (shadow_faults != CNT_MAX)
        shadow_faults++;
    end
    o.frame  = FIDX_W'(k);
    o.faults = shadow_faults;
    o.hits   = shadow_hits;
    return o;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  function automatic void push_ref(int page, bit first);
    page_ref_t r;
    r.page  = PAGE_W'(page);
    r.first = first;
    ref_queue.push_back(r);
    refs_queued++;
  endfunction

  // driver: offers the next reference item at the falling edge
  always @(negedge clk) begin : drive_refs
    page_ref_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (ref_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = ref_queue.pop_front();
        in_valid     <= 1'b1;
        page_number  <= nxt.page;
        first_of_run <= nxt.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is asked for
  always @(negedge clk) begin : drive_ready
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: checks results and predicts every accepted reference
  always @(posedge clk) begin : watch_block
    ref_outcome_t want;
    page_ref_t    taken;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end else begin
      in_taken = 1'b0;
      if (!rst) begin
        if (out_valid && out_ready) begin
          results_seen++;
          if (awaiting_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $error("result item with no reference waiting for it");
          end else begin
            want = awaiting_results.pop_front();
            check_field("hit", want.hit, hit);
            check_field("frame_index", want.frame, frame_index);
            check_field("evicted_valid", want.ev_valid, evicted_valid);
            check_field("evicted_page", want.ev_page, evicted_page);
            check_field("fault_total", want.faults, fault_total);
            check_field("hit_total", want.hits, hit_total);
            if (want.hit)
              hits_seen++;
            if (want.ev_valid)
              evictions_seen++;
          end
        end
        if (in_valid && in_ready) begin
          taken.page  = page_number;
          taken.first = first_of_run;
          awaiting_results.push_back(predict_lookup(taken));
          refs_accepted++;
          in_taken = 1'b1;
        end
      end
    end
  end

  // wait until every queued reference has been taken and answered
  task automatic wait_drained();
    while (refs_accepted != refs_queued || awaiting_results.size() != 0)
      @(negedge clk);
    // let the block settle before touching the register
    repeat (6) @(negedge clk);
  endtask

  task automatic write_frames(int value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'(4 * REG_FRAMES_IN_USE);
    pwdata  <= APB_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_frames_cfg = CFG_W'(value);
    settings_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // mostly loops over a small working set, with noise and run restarts
  task automatic add_random_refs(int n, int pool);
    int base;
    int roll;
    int added;
    base = $urandom_range(65535 - pool);
    added = 0;
    while (added < n) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        push_ref(base + $urandom_range(pool - 1), 1'b1);
        added++;
      end else if (roll < 9) begin
        push_ref($urandom & 16'hffff, 1'b0);
        added++;
      end else if (roll < 12) begin
        // move the working set, no item here
        base = $urandom_range(65535 - pool);
      end else begin
        push_ref(base + $urandom_range(pool - 1), 1'b0);
        added++;
      end
    end
  endtask

  initial begin : run_phases
    int phase_frames [RAND_PHASES];
    int active;
    phase_frames = '{3, 8, 1, 7, 8, 4};
    clear_frames();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting of eight frames: fill all, hit, then two evictions and a hit
    push_ref(0, 1'b1);
    push_ref(65535, 1'b0);
    for (int p = 1; p <= 6; p++)
      push_ref(p, 1'b0);
    push_ref(0, 1'b0);
    push_ref(7, 1'b0);
    push_ref(65535, 1'b0);
    push_ref(3, 1'b0);
    wait_drained();

    // shrink the active set; a page that still lives in an idle frame faults
    write_frames(2);
    push_ref(100, 1'b0);
    push_ref(5, 1'b0);
    push_ref(100, 1'b0);
    wait_drained();

    // zero acts as a single frame
    write_frames(0);
    push_ref(9, 1'b0);
    push_ref(9, 1'b0);
    push_ref(100, 1'b0);
    wait_drained();

    // above the row length acts as the full row; duplicates resolve low
    write_frames(15);
    push_ref(5, 1'b0);
    push_ref(65535, 1'b0);
    push_ref(7, 1'b0);
    push_ref(42, 1'b1);
    wait_drained();

    // random phases: sender light and receiver heavy, then swapped, then free
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 2)
        set_idling(10, 74);
      else if (ph < 4)
        set_idling(74, 10);
      else
        set_idling(0, 0);
      write_frames(phase_frames[ph]);
      if (ph == 2) begin
        // receiver stops for a long stretch while items keep coming
        set_idling(0, 10);
        hold_asks++;
      end
      active = phase_frames[ph];
      add_random_refs(PHASE_REFS, active + $urandom_range(4));
      wait_drained();
    end
    repeat (20) @(posedge clk);

    $display("%0d references checked over %0d register settings: %0d hits, %0d evictions",
             refs_accepted, settings_used, hits_seen, evictions_seen);
    $display("covered idle phases, run restarts and a %0d cycle receiver stall",
             HOLD_CYCLES);
    if (mismatches == 0 && awaiting_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
